>>> rtl/bfpu_pkg.sv
// Shared types and constants for the bit field packer/unpacker.
// Used by the channel interfaces, controller, datapath and top level.
package bfpu_pkg;

    localparam int KIND_W    = 2;
    localparam int COUNT_W   = 6;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 12;
    localparam int ADDR_W    = 8;
    localparam int DATA_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int BANKS     = 4;
    localparam int BANK_W    = 2;
    localparam int WINDOW_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET = 2'd0,
        KIND_PUT = 2'd1,
        KIND_GET = 2'd2,
        KIND_RAW = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_WINDOW = 2'd1,
        ST_END    = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // input transaction taken this cycle
        logic finish;      // complete item: write back, load output register
        logic clear_step;  // zero one buffer row
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;  // current clear row is the final one
    } t_dp_stat;

endpackage

>>> rtl/bfpu_if.sv
// Valid/ready channel interfaces for the bit field packer/unpacker.
// Depends on bfpu_pkg for field widths.
interface bfpu_in_if;
    import bfpu_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [COUNT_W-1:0]   bit_count;
    logic [VALUE_W-1:0]   field_value;
    logic [POS_W-1:0]     new_position;
    logic [ADDR_W-1:0]    byte_address;
    logic [DATA_W-1:0]    byte_data;

    modport source (output valid, kind, bit_count, field_value, new_position,
                    byte_address, byte_data, input ready);
    modport sink   (input valid, kind, bit_count, field_value, new_position,
                    byte_address, byte_data, output ready);
endinterface

interface bfpu_out_if;
    import bfpu_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   read_value;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     cursor_now;

    modport source (output valid, read_value, status, cursor_now, input ready);
    modport sink   (input valid, read_value, status, cursor_now, output ready);
endinterface

>>> rtl/bfpu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/bfpu_ctrl.sv
// Controller: clear sweep after reset, accept/execute sequencing, output valid.
// Depends on bfpu_pkg for the command and status structs.
module bfpu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output bfpu_pkg::t_ctrl_cmd  o_cmd,
    input  bfpu_pkg::t_dp_stat   i_stat
);
    import bfpu_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cmd.accept     = i_in_valid && o_in_ready;
    // output slot free, or its transaction completes this cycle
    assign o_cmd.finish     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_cmd.clear_step = (r_state == S_CLEAR);
    assign o_out_valid      = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clear_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd.accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (o_cmd.finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase

            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execute");

    a_valid_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result raised without an item in execute");

    a_exec_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && o_out_valid && !i_out_ready)
        |=> (r_state == S_EXEC && o_out_valid))
        else $error("blocked result lost while item waits");
`endif
endmodule

>>> rtl/bfpu_dp.sv
// Datapath: cursor, window checks, four byte-interleaved buffer banks,
// field insert/extract and output payload register.
// Depends on bfpu_pkg and bfpu_ram.
module bfpu_dp #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfpu_pkg::t_ctrl_cmd           i_cmd,
    output bfpu_pkg::t_dp_stat            o_stat,
    input  logic [bfpu_pkg::KIND_W-1:0]   i_kind,
    input  logic [bfpu_pkg::COUNT_W-1:0]  i_bit_count,
    input  logic [bfpu_pkg::VALUE_W-1:0]  i_field_value,
    input  logic [bfpu_pkg::POS_W-1:0]    i_new_position,
    input  logic [bfpu_pkg::ADDR_W-1:0]   i_byte_address,
    input  logic [bfpu_pkg::DATA_W-1:0]   i_byte_data,
    output logic [bfpu_pkg::VALUE_W-1:0]  o_read_value,
    output logic [bfpu_pkg::STATUS_W-1:0] o_status,
    output logic [bfpu_pkg::POS_W-1:0]    o_cursor_now
);
    import bfpu_pkg::*;

    localparam int ROWS     = (BUFFER_BYTES + BANKS - 1) / BANKS;
    localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BUF_BITS = 8 * BUFFER_BYTES;
    localparam int BA_W     = POS_W - 2;   // byte address of cursor window, +3 fits

    // cursor and clear sweep
    logic [POS_W-1:0] r_cursor;
    logic [RW-1:0]    r_clr_row;

    // accept-stage decode
    t_kind                 w_kind;
    logic [2:0]            w_off;
    logic [BA_W-1:0]       w_base;
    logic [6:0]            w_win_sum;
    logic [POS_W:0]        w_end_sum;
    logic                  w_win_err;
    logic                  w_end_err;
    t_status               w_status;
    logic [COUNT_W-1:0]    w_shift;
    logic [WINDOW_W-1:0]   w_mask;
    logic [WINDOW_W-1:0]   w_placed;
    logic                  w_raw_ok;
    logic [31:0]           w_raw_row;
    logic [BA_W-1:0]       w_addr  [BANKS];
    logic [31:0]           w_row32 [BANKS];
    logic [RW-1:0]         w_row   [BANKS];
    logic [BANKS-1:0]      w_bank_ok;
    logic [BYTE_W-1:0]     w_pbyte [BANKS];

    // execute-stage registers
    logic [RW-1:0]         r_row   [BANKS];
    logic [BANKS-1:0]      r_wen;
    logic [BYTE_W-1:0]     r_wbyte [BANKS];
    logic [BANKS-1:0]      r_bank_ok;
    logic                  r_merge;
    logic                  r_get_ok;
    logic [BANK_W-1:0]     r_base_lo;
    logic [COUNT_W-1:0]    r_shift;
    logic [WINDOW_W-1:0]   r_mask;
    t_status               r_status;

    // output payload
    logic [VALUE_W-1:0]    r_out_value;
    logic [STATUS_W-1:0]   r_out_status;
    logic [POS_W-1:0]      r_out_cursor;

    // bank ports
    logic [BANKS-1:0]      w_we;
    logic [RW-1:0]         w_waddr [BANKS];
    logic [BYTE_W-1:0]     w_wdata [BANKS];
    logic [BYTE_W-1:0]     w_rdata [BANKS];
    logic [WINDOW_W-1:0]   w_window;
    logic [VALUE_W-1:0]    w_read_value;

    assign w_kind    = t_kind'(i_kind);
    assign w_off     = r_cursor[2:0];
    assign w_base    = {1'b0, r_cursor[POS_W-1:3]};
    assign w_win_sum = {4'b0, w_off} + {1'b0, i_bit_count};
    assign w_end_sum = {1'b0, r_cursor} + {{(POS_W + 1 - COUNT_W){1'b0}}, i_bit_count};
    assign w_win_err = (w_win_sum > 7'(WINDOW_W));
    assign w_end_err = ({{(31 - POS_W){1'b0}}, w_end_sum} > 32'(BUF_BITS));
    assign w_shift   = COUNT_W'(7'(WINDOW_W) - w_win_sum);
    assign w_mask    = ~({WINDOW_W{1'b1}} << i_bit_count);
    assign w_placed  = (i_field_value & w_mask) << w_shift;
    assign w_raw_ok  = ({24'b0, i_byte_address} < 32'(BUFFER_BYTES));
    assign w_raw_row = {26'b0, i_byte_address[ADDR_W-1:2]};

    always_comb begin
        if (w_kind == KIND_PUT || w_kind == KIND_GET) begin
            priority if (w_win_err) w_status = ST_WINDOW;
            else if (w_end_err)     w_status = ST_END;
            else                    w_status = ST_OK;
        end else begin
            w_status = ST_OK;
        end
    end

    // bank j holds window byte k where (base + k) mod 4 == j
    always_comb begin
        for (int j = 0; j < BANKS; j++) begin
            w_addr[j]    = w_base + BA_W'(BANK_W'(j[BANK_W-1:0] - w_base[BANK_W-1:0]));
            w_row32[j]   = {{(32 - BA_W + 2){1'b0}}, w_addr[j][BA_W-1:2]};
            w_row[j]     = w_row32[j][RW-1:0];
            w_bank_ok[j] = ({{(32 - BA_W){1'b0}}, w_addr[j]} < 32'(BUFFER_BYTES));
            w_pbyte[j]   = w_placed[BYTE_W * (BANKS - 1 - int'(BANK_W'(j[BANK_W-1:0]
                                     - w_base[BANK_W-1:0]))) +: BYTE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_clr_row <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_row <= r_clr_row + RW'(1);
            end
            if (i_cmd.accept) begin
                if (w_kind == KIND_SET) begin
                    r_cursor <= i_new_position;
                end else if ((w_kind == KIND_PUT || w_kind == KIND_GET)
                             && w_status == ST_OK) begin
                    r_cursor <= w_end_sum[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_merge   <= (w_kind == KIND_PUT);
            r_get_ok  <= (w_kind == KIND_GET) && (w_status == ST_OK);
            r_base_lo <= w_base[BANK_W-1:0];
            r_shift   <= w_shift;
            r_mask    <= w_mask;
            r_status  <= w_status;
            r_bank_ok <= w_bank_ok;
            for (int j = 0; j < BANKS; j++) begin
                unique case (w_kind)
                    KIND_RAW: begin
                        r_row[j]   <= w_raw_row[RW-1:0];
                        r_wbyte[j] <= i_byte_data;
                        r_wen[j]   <= w_raw_ok
                                      && (i_byte_address[BANK_W-1:0] == BANK_W'(j));
                    end
                    KIND_PUT: begin
                        r_row[j]   <= w_row[j];
                        r_wbyte[j] <= w_pbyte[j];
                        r_wen[j]   <= w_bank_ok[j] && (w_status == ST_OK);
                    end
                    KIND_SET, KIND_GET: begin
                        r_row[j]   <= w_row[j];
                        r_wbyte[j] <= w_pbyte[j];
                        r_wen[j]   <= 1'b0;
                    end
                    default: begin
                        r_row[j]   <= w_row[j];
                        r_wbyte[j] <= w_pbyte[j];
                        r_wen[j]   <= 1'b0;
                    end
                endcase
            end
        end
    end

    // write port: clear sweep, else write-back at finish
    always_comb begin
        for (int j = 0; j < BANKS; j++) begin
            if (i_cmd.clear_step) begin
                w_we[j]    = 1'b1;
                w_waddr[j] = r_clr_row;
                w_wdata[j] = '0;
            end else begin
                w_we[j]    = i_cmd.finish && r_wen[j];
                w_waddr[j] = r_row[j];
                w_wdata[j] = r_merge ? (w_rdata[j] | r_wbyte[j]) : r_wbyte[j];
            end
        end
    end

    for (genvar g = 0; g < BANKS; g++) begin : g_bank
        bfpu_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_waddr[g]),
            .i_wdata (w_wdata[g]),
            .i_re    (i_cmd.accept),
            .i_raddr (w_row[g]),
            .o_rdata (w_rdata[g])
        );
    end

    // window byte k comes from bank (base + k) mod 4; bytes past the end read zero
    always_comb begin
        for (int k = 0; k < BANKS; k++) begin
            w_window[BYTE_W * (BANKS - 1 - k) +: BYTE_W] =
                r_bank_ok[BANK_W'(r_base_lo + BANK_W'(k))]
                ? w_rdata[BANK_W'(r_base_lo + BANK_W'(k))] : '0;
        end
    end

    assign w_read_value = r_get_ok ? ((w_window >> r_shift) & r_mask) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value  <= w_read_value;
            r_out_status <= r_status;
            r_out_cursor <= r_cursor;
        end
    end

    assign o_stat.clear_last = (r_clr_row == RW'(ROWS - 1));
    assign o_read_value      = r_out_value;
    assign o_status          = r_out_status;
    assign o_cursor_now      = r_out_cursor;
endmodule

>>> rtl/bit_field_packer_unpacker.sv
// MSB-first bit field packer/unpacker over a byte buffer with a bit cursor.
// Result: finish loads the output register; it waits while a result is unread.
// Each item: bank read, then write-back/extract; no new item is taken meanwhile.
// Reset: cursor cleared; the buffer is zeroed by a sweep of ceil(BUFFER_BYTES/4)
// rows (64 at the default size) during which the input is not ready.
// Depends on bfpu_pkg, bfpu_if, bfpu_ctrl, bfpu_dp, bfpu_ram.
module bit_field_packer_unpacker #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfpu_in_if.sink       i_in,
    bfpu_out_if.source    o_out
);
    import bfpu_pkg::*;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    bfpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    bfpu_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_kind         (i_in.kind),
        .i_bit_count    (i_in.bit_count),
        .i_field_value  (i_in.field_value),
        .i_new_position (i_in.new_position),
        .i_byte_address (i_in.byte_address),
        .i_byte_data    (i_in.byte_data),
        .o_read_value   (o_out.read_value),
        .o_status       (o_out.status),
        .o_cursor_now   (o_out.cursor_now)
    );
endmodule
